### rtl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

  localparam int DATA_W   = 16;
  localparam int ONE_Q14  = 16384;
  localparam int SQ_W     = 32;
  localparam int LEN_RW   = 24;
  localparam int COEF_QW  = 15;
  localparam int COEF_W   = 16;
  localparam int DIFF_W   = 17;
  localparam int TRACE_W  = 18;
  localparam int ROOT_RW  = 16;
  localparam int QUAT_QW  = 22;

  typedef logic [8:0][DATA_W-1:0] mat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] m_r0c0;
    logic signed [DATA_W-1:0] m_r0c1;
    logic signed [DATA_W-1:0] m_r0c2;
    logic signed [DATA_W-1:0] m_r1c0;
    logic signed [DATA_W-1:0] m_r1c1;
    logic signed [DATA_W-1:0] m_r1c2;
    logic signed [DATA_W-1:0] m_r2c0;
    logic signed [DATA_W-1:0] m_r2c1;
    logic signed [DATA_W-1:0] m_r2c2;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;
    logic                     degenerate;
  } out_t;

  typedef struct packed {
    logic       trace_pos;
    logic       degen;
    logic [1:0] axis;
  } sel_t;

endpackage
`default_nettype wire

### rtl/rmq_isqrt.sv
`default_nettype none
module rmq_isqrt import rmq_pkg::*; #(
  parameter int RW = ROOT_RW
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*RW-1:0] rad,
  output logic      [RW-1:0]   root
);

  logic [2*RW-1:0] x_r    [RW-1];
  logic [RW+1:0]   rem_r  [RW-1];
  logic [RW-1:0]   root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [2*RW-1:0] x_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [RW+1:0]   acc;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign x_in    = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign acc   = {rem_in[RW-1:0], x_in[2*RW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[RW-2:0], ge};
      end
    end

    if (k < RW-1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k]   <= x_in << 2;
          rem_r[k] <= ge ? acc - trial : acc;
        end
      end
    end
  end

  assign root = root_r[RW-1];

endmodule
`default_nettype wire

### rtl/rmq_div.sv
`default_nettype none
module rmq_div import rmq_pkg::*; #(
  parameter int NW = 30,
  parameter int DW = 17,
  parameter int QW = QUAT_QW
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [W-1:0]  shifted;
    logic          ge;
    logic [QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = W'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign shifted = W'(den_in) << (QW-1-k);
    assign ge      = rem_in >= shifted;

    always_comb begin
      q_nxt            = q_in;
      q_nxt[QW-1-k]    = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_nxt;
      end
    end

    if (k < QW-1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_in - shifted : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule
`default_nettype wire

### rtl/rotation_matrix_to_quaternion_top.sv
// Channel  Direction  Payload  Handshake
// in_      input      in_t     in_valid / in_stall
// out_     output     out_t    out_valid / out_stall
//
// One transaction is accepted per cycle unless the output is stalled. A
// result passes the bit-per-stage pipelines: the 24-stage column length
// root, the 15-stage normalising divider, the 16-stage root and the
// 22-stage component divider. Reset clears only the valid bits.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
`default_nettype none
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int LAT = 5 + LEN_RW + COEF_QW + ROOT_RW + QUAT_QW;

  logic en;
  logic vld_r [LAT];
  mat_t mat_in;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  assign mat_in = {in_data.m_r2c2, in_data.m_r2c1, in_data.m_r2c0,
                   in_data.m_r1c2, in_data.m_r1c1, in_data.m_r1c0,
                   in_data.m_r0c2, in_data.m_r0c1, in_data.m_r0c0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  logic [SQ_W-2:0] sqp_r [9];
  mat_t            mat1_r;
  logic [SQ_W-1:0] sq_r  [3];
  mat_t            mat2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        sqp_r[e] <= (SQ_W-1)'($signed(mat_in[e]) * $signed(mat_in[e]));
      end
      mat1_r <= mat_in;
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= SQ_W'(sqp_r[c]) + SQ_W'(sqp_r[3+c]) + SQ_W'(sqp_r[6+c]);
      end
      mat2_r <= mat1_r;
    end
  end

  logic [LEN_RW-1:0] len [3];

  for (genvar c = 0; c < 3; c++) begin : g_len
    rmq_isqrt #(.RW(LEN_RW)) u_len (
      .clk (clk),
      .en  (en),
      .rad ({sq_r[c], (2*LEN_RW-SQ_W)'(0)}),
      .root(len[c])
    );
  end

  mat_t       matd_r  [LEN_RW];
  logic [2:0] zerod_r [LEN_RW];

  always_ff @(posedge clk) begin
    if (en) begin
      matd_r[0]  <= mat2_r;
      zerod_r[0] <= {sq_r[2] == '0, sq_r[1] == '0, sq_r[0] == '0};
      for (int i = 1; i < LEN_RW; i++) begin
        matd_r[i]  <= matd_r[i-1];
        zerod_r[i] <= zerod_r[i-1];
      end
    end
  end

  localparam int CN_W = DATA_W + 23;

  logic [COEF_QW-1:0] nq [9];
  logic [8:0]         negd_r  [COEF_QW];
  logic [2:0]         zero2_r [COEF_QW];

  for (genvar e = 0; e < 9; e++) begin : g_norm
    logic signed [DATA_W-1:0] v;
    logic [DATA_W-1:0]        mag;

    assign v   = $signed(matd_r[LEN_RW-1][e]);
    assign mag = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);

    rmq_div #(.NW(CN_W), .DW(LEN_RW+1), .QW(COEF_QW)) u_norm (
      .clk(clk),
      .en (en),
      .num({mag, 23'd0} + CN_W'(len[e % 3])),
      .den({len[e % 3], 1'b0}),
      .quo(nq[e])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) negd_r[0][e] <= matd_r[LEN_RW-1][e][DATA_W-1];
      zero2_r[0] <= zerod_r[LEN_RW-1];
      for (int i = 1; i < COEF_QW; i++) begin
        negd_r[i]  <= negd_r[i-1];
        zero2_r[i] <= zero2_r[i-1];
      end
    end
  end

  logic signed [COEF_W-1:0] cf_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          logic [COEF_W-1:0] qc;
          qc = (COEF_W'(nq[r*3+c]) > COEF_W'(ONE_Q14)) ? COEF_W'(ONE_Q14)
                                                       : COEF_W'(nq[r*3+c]);
          if (zero2_r[COEF_QW-1][c]) begin
            cf_r[c][r] <= '0;
          end else if (negd_r[COEF_QW-1][r*3+c]) begin
            cf_r[c][r] <= -$signed(qc);
          end else begin
            cf_r[c][r] <= $signed(qc);
          end
        end
      end
    end
  end

  logic signed [TRACE_W-1:0] trace;
  logic signed [TRACE_W-1:0] tval;
  logic [1:0]                ax;
  logic [1:0]                jx;
  logic [1:0]                kx;
  logic signed [DIFF_W-1:0]  d_nxt [3];
  logic [2*ROOT_RW-1:0]      rad_nxt;
  sel_t                      sel_nxt;

  always_comb begin
    trace = TRACE_W'(cf_r[0][0]) + TRACE_W'(cf_r[1][1]) + TRACE_W'(cf_r[2][2]);
    ax = 2'd0;
    if (cf_r[1][1] > cf_r[0][0]) ax = 2'd1;
    if (cf_r[2][2] > cf_r[ax][ax]) ax = 2'd2;
    case (ax)
      2'd0:    begin jx = 2'd1; kx = 2'd2; end
      2'd1:    begin jx = 2'd2; kx = 2'd0; end
      default: begin jx = 2'd0; kx = 2'd1; end
    endcase
    tval = TRACE_W'(cf_r[ax][ax]) - TRACE_W'(cf_r[jx][jx]) - TRACE_W'(cf_r[kx][kx])
           + TRACE_W'(ONE_Q14);
    sel_nxt.trace_pos = trace > 0;
    sel_nxt.degen     = !(trace > 0) && !(tval > 0);
    sel_nxt.axis      = ax;
    if (trace > 0) begin
      d_nxt[0] = DIFF_W'(cf_r[2][1]) - DIFF_W'(cf_r[1][2]);
      d_nxt[1] = DIFF_W'(cf_r[0][2]) - DIFF_W'(cf_r[2][0]);
      d_nxt[2] = DIFF_W'(cf_r[1][0]) - DIFF_W'(cf_r[0][1]);
      rad_nxt  = (2*ROOT_RW)'(trace + TRACE_W'(ONE_Q14)) << 14;
    end else begin
      d_nxt[0] = DIFF_W'(cf_r[ax][jx]) + DIFF_W'(cf_r[jx][ax]);
      d_nxt[1] = DIFF_W'(cf_r[kx][ax]) + DIFF_W'(cf_r[ax][kx]);
      d_nxt[2] = DIFF_W'(cf_r[kx][jx]) - DIFF_W'(cf_r[jx][kx]);
      rad_nxt  = (tval > 0) ? (2*ROOT_RW)'(tval) << 14 : '0;
    end
  end

  logic signed [DIFF_W-1:0] d4_r [3];
  logic [2*ROOT_RW-1:0]     rad4_r;
  sel_t                     sel4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d4_r[i] <= d_nxt[i];
      rad4_r <= rad_nxt;
      sel4_r <= sel_nxt;
    end
  end

  logic [ROOT_RW-1:0] sroot;

  rmq_isqrt #(.RW(ROOT_RW)) u_root (
    .clk (clk),
    .en  (en),
    .rad (rad4_r),
    .root(sroot)
  );

  logic signed [DIFF_W-1:0] dd_r   [ROOT_RW][3];
  sel_t                     seld_r [ROOT_RW];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) dd_r[0][n] <= d4_r[n];
      seld_r[0] <= sel4_r;
      for (int i = 1; i < ROOT_RW; i++) begin
        for (int n = 0; n < 3; n++) dd_r[i][n] <= dd_r[i-1][n];
        seld_r[i] <= seld_r[i-1];
      end
    end
  end

  localparam int QN_W = DATA_W + 14;

  logic [QUAT_QW-1:0] cq [3];

  for (genvar n = 0; n < 3; n++) begin : g_comp
    logic signed [DIFF_W-1:0] dv;
    logic [DATA_W-1:0]        mag;

    assign dv  = dd_r[ROOT_RW-1][n];
    assign mag = dv[DIFF_W-1] ? DATA_W'(-dv) : DATA_W'(dv);

    rmq_div #(.NW(QN_W), .DW(ROOT_RW+1), .QW(QUAT_QW)) u_comp (
      .clk(clk),
      .en (en),
      .num({mag, 14'd0} + QN_W'(sroot)),
      .den({sroot, 1'b0}),
      .quo(cq[n])
    );
  end

  logic [ROOT_RW-1:0] majd_r [QUAT_QW];
  logic [2:0]         cnegd_r [QUAT_QW];
  sel_t               sel2_r [QUAT_QW];

  always_ff @(posedge clk) begin
    if (en) begin
      majd_r[0] <= ROOT_RW'(({1'b0, sroot} + (ROOT_RW+1)'(1)) >> 1);
      for (int n = 0; n < 3; n++) cnegd_r[0][n] <= dd_r[ROOT_RW-1][n][DIFF_W-1];
      sel2_r[0] <= seld_r[ROOT_RW-1];
      for (int i = 1; i < QUAT_QW; i++) begin
        majd_r[i]  <= majd_r[i-1];
        cnegd_r[i] <= cnegd_r[i-1];
        sel2_r[i]  <= sel2_r[i-1];
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] sat(input logic [QUAT_QW-1:0] q,
                                                   input logic neg);
    logic signed [QUAT_QW:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > (QUAT_QW+1)'(32767)) return DATA_W'(32767);
    if (v < -(QUAT_QW+1)'(32768)) return DATA_W'(-32768);
    return DATA_W'(v);
  endfunction

  logic signed [DATA_W-1:0] cs [3];
  logic signed [DATA_W-1:0] qv [4];
  sel_t                     fsel;

  always_comb begin
    fsel = sel2_r[QUAT_QW-1];
    for (int n = 0; n < 3; n++) cs[n] = sat(cq[n], cnegd_r[QUAT_QW-1][n]);
    for (int n = 0; n < 4; n++) qv[n] = '0;
    if (fsel.trace_pos) begin
      qv[0] = cs[0];
      qv[1] = cs[1];
      qv[2] = cs[2];
      qv[3] = $signed(majd_r[QUAT_QW-1]);
    end else if (!fsel.degen) begin
      case (fsel.axis)
        2'd0:    begin qv[0] = $signed(majd_r[QUAT_QW-1]); qv[1] = cs[0]; qv[2] = cs[1]; end
        2'd1:    begin qv[1] = $signed(majd_r[QUAT_QW-1]); qv[2] = cs[0]; qv[0] = cs[1]; end
        default: begin qv[2] = $signed(majd_r[QUAT_QW-1]); qv[0] = cs[0]; qv[1] = cs[1]; end
      endcase
      qv[3] = cs[2];
    end
  end

  out_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.quat_x     <= qv[0];
      out_r.quat_y     <= qv[1];
      out_r.quat_z     <= qv[2];
      out_r.quat_w     <= qv[3];
      out_r.degenerate <= fsel.degen;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### tb/sv/rmq_checker.sv
module rmq_checker import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire out_t out_data,
  output int        fail_count,
  output int        pending_count,
  output int        seen_count,
  output int        degen_count
);

  out_t quat_queue[$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7fff;
    return v[15:0];
  endfunction

  function automatic out_t predict_quat(in_t d);
    longint m[3][3];
    longint cf[3][3];
    longint q[4];
    longint sq, len, tr, t, s, n;
    int ai, aj, ak;
    out_t o;
    m[0][0] = d.m_r0c0; m[0][1] = d.m_r0c1; m[0][2] = d.m_r0c2;
    m[1][0] = d.m_r1c0; m[1][1] = d.m_r1c1; m[1][2] = d.m_r1c2;
    m[2][0] = d.m_r2c0; m[2][1] = d.m_r2c1; m[2][2] = d.m_r2c2;
    for (int i = 0; i < 4; i++) q[i] = 0;
    o.degenerate = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sq = m[0][c] * m[0][c] + m[1][c] * m[1][c] + m[2][c] * m[2][c];
      len = (sq == 0) ? 1 : longint'(int_sqrt(longint'(sq) << 16));
      for (int r = 0; r < 3; r++) begin
        if (sq == 0) begin
          cf[c][r] = 0;
        end else begin
          n = round_div(m[r][c] * 4194304, len);
          cf[c][r] = (n < -ONE_Q14) ? -ONE_Q14 : ((n > ONE_Q14) ? ONE_Q14 : n);
        end
      end
    end
    tr = cf[0][0] + cf[1][1] + cf[2][2];
    if (tr > 0) begin
      s = int_sqrt((tr + ONE_Q14) << 14);
      q[3] = round_div(s, 2);
      q[0] = round_div((cf[2][1] - cf[1][2]) * 8192, s);
      q[1] = round_div((cf[0][2] - cf[2][0]) * 8192, s);
      q[2] = round_div((cf[1][0] - cf[0][1]) * 8192, s);
    end else begin
      ai = 0;
      if (cf[1][1] > cf[0][0]) ai = 1;
      if (cf[2][2] > cf[ai][ai]) ai = 2;
      aj = (ai + 1) % 3;
      ak = (aj + 1) % 3;
      t = cf[ai][ai] - cf[aj][aj] - cf[ak][ak] + ONE_Q14;
      if (t <= 0) begin
        o.degenerate = 1'b1;
      end else begin
        s = int_sqrt(t << 14);
        q[ai] = round_div(s, 2);
        q[aj] = round_div((cf[ai][aj] + cf[aj][ai]) * 8192, s);
        q[ak] = round_div((cf[ak][ai] + cf[ai][ak]) * 8192, s);
        q[3] = round_div((cf[ak][aj] - cf[aj][ak]) * 8192, s);
      end
    end
    o.quat_x = sat16(q[0]);
    o.quat_y = sat16(q[1]);
    o.quat_z = sat16(q[2]);
    o.quat_w = sat16(q[3]);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    seen_count = 0;
    degen_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && !in_stall) quat_queue.push_back(predict_quat(in_data));
    if (rst_n && out_valid && !out_stall) begin
      seen_count++;
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = quat_queue.pop_front();
        if (want.degenerate) degen_count++;
        if (out_data.quat_x !== want.quat_x)
          report_mismatch("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y)
          report_mismatch("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z)
          report_mismatch("quat_z", out_data.quat_z, want.quat_z);
        if (out_data.quat_w !== want.quat_w)
          report_mismatch("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.degenerate !== want.degenerate)
          report_mismatch("degenerate", out_data.degenerate, want.degenerate);
      end
    end
    pending_count = quat_queue.size();
  end

endmodule

### tb/sv/tb_rotation_matrix_to_quaternion_top.sv
module tb_rotation_matrix_to_quaternion_top;
  import rmq_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count, pending_count, seen_count, degen_count;
  int   cycle_count;
  int   send_idle_pct, recv_idle_pct;

  rotation_matrix_to_quaternion_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rmq_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .seen_count(seen_count), .degen_count(degen_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("rotation_matrix_to_quaternion_top regression: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [15:0] pick_elem(int style);
    case (style)
      0: return $urandom();
      1: return 16'($signed($urandom_range(8192)) - 4096);
      2: return 16'($signed($urandom_range(64)) - 32);
      default: begin
        case ($urandom_range(5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'h1000;
          4: return 16'hf000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  function automatic in_t make_matrix(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                      logic [15:0] d, logic [15:0] e, logic [15:0] f,
                                      logic [15:0] g, logic [15:0] h, logic [15:0] k);
    in_t v;
    v = {a, b, c, d, e, f, g, h, k};
    return v;
  endfunction

  function automatic in_t rotation_like();
    in_t v;
    int ci, sn, sg, ax;
    ci = $urandom_range(8192) - 4096;
    sg = $urandom_range(1) ? 1 : -1;
    sn = sg * $rtoi($sqrt(16777216.0 - ci * ci));
    ax = $urandom_range(2);
    case (ax)
      0: v = make_matrix(16'h1000, 0, 0, 0, 16'(ci), 16'(-sn), 0, 16'(sn), 16'(ci));
      1: v = make_matrix(16'(ci), 0, 16'(sn), 0, 16'h1000, 0, 16'(-sn), 0, 16'(ci));
      default: v = make_matrix(16'(ci), 16'(-sn), 0, 16'(sn), 16'(ci), 0, 0, 0, 16'h1000);
    endcase
    if ($urandom_range(3) == 0) v.m_r0c0 = -v.m_r0c0;
    return v;
  endfunction

  task automatic send_matrix(in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    in_t v;
    int style;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 60) begin
        v = rotation_like();
      end else begin
        style = $urandom_range(3);
        v = make_matrix(pick_elem(style), pick_elem(style), pick_elem(style),
                        pick_elem(style), pick_elem(style), pick_elem(style),
                        pick_elem(style), pick_elem(style), pick_elem(style));
      end
      send_matrix(v);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 65;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_matrix('0);
    send_matrix(make_matrix(16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000));
    send_matrix(make_matrix(16'h1000, 0, 0, 0, 16'hf000, 0, 0, 0, 16'hf000));
    send_matrix(make_matrix(16'hf000, 0, 0, 0, 16'h1000, 0, 0, 0, 16'hf000));
    send_matrix(make_matrix(16'hf000, 0, 0, 0, 16'hf000, 0, 0, 0, 16'h1000));
    send_matrix(make_matrix(16'hf000, 0, 0, 0, 16'hf000, 0, 0, 0, 16'hf000));
    send_matrix(make_matrix(0, 16'hf000, 0, 16'h1000, 0, 0, 0, 0, 16'h1000));
    send_matrix(make_matrix(16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0, 0));
    send_matrix(make_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_matrix(make_matrix(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_matrix(make_matrix(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                            16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    send_matrix(make_matrix(16'h0001, 0, 0, 0, 16'hffff, 0, 0, 0, 16'h0001));
    send_matrix(make_matrix(16'hf000, 0, 0, 0, 16'hf000, 0, 0, 0, 0));
    send_matrix(make_matrix(0, 16'h1000, 0, 16'h1000, 0, 0, 0, 0, 16'hf000));
    send_matrix(make_matrix(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                            16'hffff, 16'hffff, 16'hffff, 16'hffff));

    send_random(200);
    send_idle_pct = 65;
    recv_idle_pct = 21;
    send_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(200);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("checked %0d quaternions, %0d of them degenerate", seen_count, degen_count);
    $display("stimulus: axes, extremes, zero columns, near-rotations and random matrices");
    if (fail_count == 0) begin
      $display("rotation_matrix_to_quaternion_top regression: pass");
    end else begin
      $display("rotation_matrix_to_quaternion_top regression: fail");
    end
    $finish;
  end

endmodule
